// File: rtl/core/bb3_pkg.sv
// bb3_pkg: shared types, widths and constants of the 3x3 box blur
// used by bb3_win, bb3_div and box_blur_3x3_edge_clipped
`default_nettype none

package bb3_pkg;

    // field and register widths
    localparam int unsigned CH_W       = 8;
    localparam int unsigned PIX_W      = 3 * CH_W;
    localparam int unsigned CFG_W_BITS = 11;
    localparam int unsigned CFG_H_BITS = 13;
    localparam int unsigned CFG_D_BITS = 13;
    localparam int unsigned ROW_BITS   = CFG_H_BITS + 1;

    // window sum and clipped pixel count
    localparam int unsigned SUM_W = 12;
    localparam int unsigned CNT_W = 4;

    // reciprocal divide of (2*sum + count) by 2*count
    localparam int unsigned NUM_W       = SUM_W + 1;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;

    // register reset values
    localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = 13'd768;

    // request kinds carried on the slave tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_state;

    // window control from the sequencer
    typedef struct packed {
        logic       shift;
        logic       sum_en;
        logic [2:0] row_use;
        logic [2:0] col_use;
    } t_win_ctrl;

    // registered window sums and pixel count
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
    } t_win_sum;

    // ceil(2^18 / (2*count)), exact floor division for numerators below 2^13
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bb3_line_mem.sv
// bb3_line_mem: the two line stores of the blur, one row of {upper, middle} per column
// simple dual port memory with registered read, no package dependency
`default_nettype none

module bb3_line_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/bb3_win.sv
// bb3_win: 3x3 pixel window and its clipped per-channel sums
// depends on bb3_pkg for the control and sum structs
`default_nettype none

module bb3_win (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bb3_pkg::t_win_ctrl             i_ctrl,
    input  wire logic [bb3_pkg::PIX_W-1:0]      i_upper,
    input  wire logic [bb3_pkg::PIX_W-1:0]      i_middle,
    input  wire logic [bb3_pkg::PIX_W-1:0]      i_pix,
    output bb3_pkg::t_win_sum                   o_sum
);

    import bb3_pkg::*;

    // [row oldest..newest][column oldest..newest], red in the high byte
    logic [PIX_W-1:0] r_win [3][3];
    logic [SUM_W-1:0] n_red, n_green, n_blue;
    logic [1:0]       n_rows, n_cols;
    logic [CNT_W-1:0] n_count;
    t_win_sum         r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_ctrl.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_pix;
        end
    end

    // center sits in column 1, row 1; masks drop what lies outside the frame
    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_ctrl.row_use[i] && i_ctrl.col_use[j]) begin
                    n_red   = n_red   + SUM_W'(r_win[i][j][2*CH_W +: CH_W]);
                    n_green = n_green + SUM_W'(r_win[i][j][CH_W +: CH_W]);
                    n_blue  = n_blue  + SUM_W'(r_win[i][j][0 +: CH_W]);
                end
            end
        end
        n_rows  = 2'(i_ctrl.row_use[0]) + 2'(i_ctrl.row_use[1]) + 2'(i_ctrl.row_use[2]);
        n_cols  = 2'(i_ctrl.col_use[0]) + 2'(i_ctrl.col_use[1]) + 2'(i_ctrl.col_use[2]);
        n_count = {2'b00, n_rows} * {2'b00, n_cols};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_sum.red   <= n_red;
            r_sum.green <= n_green;
            r_sum.blue  <= n_blue;
            r_sum.count <= n_count;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// File: rtl/core/bb3_div.sv
// bb3_div: rounded mean per channel, (2*sum + count) / (2*count)
// reciprocal multiply from bb3_pkg::recip, one registered product per channel
`default_nettype none

module bb3_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire bb3_pkg::t_win_sum          i_sum,
    output logic [bb3_pkg::CH_W-1:0]        o_red,
    output logic [bb3_pkg::CH_W-1:0]        o_green,
    output logic [bb3_pkg::CH_W-1:0]        o_blue
);

    import bb3_pkg::*;

    logic [SUM_W-1:0]   sums   [3];
    logic [NUM_W-1:0]   num    [3];
    logic [RECIP_W-1:0] m;
    logic [PROD_W-1:0]  r_prod [3];

    assign sums[0] = i_sum.red;
    assign sums[1] = i_sum.green;
    assign sums[2] = i_sum.blue;
    assign m       = recip(i_sum.count);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k] = {sums[k], 1'b0} + NUM_W'(i_sum.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= {{RECIP_W{1'b0}}, num[k]} * {{NUM_W{1'b0}}, m};
            end
        end
    end

    // quotient never exceeds 255
    assign o_red   = r_prod[0][RECIP_SHIFT +: CH_W];
    assign o_green = r_prod[1][RECIP_SHIFT +: CH_W];
    assign o_blue  = r_prod[2][RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

// File: rtl/core/box_blur_3x3_edge_clipped.sv
// box_blur_3x3_edge_clipped: top level of the streaming 3x3 box blur
// depends on bb3_pkg, bb3_line_mem, bb3_win and bb3_div
//
// RGB pixels of one frame enter in raster order and leave replaced by the
// half-up rounded mean of their 3x3 neighbourhood, clipped at the borders
// (4 pixels at a corner, 6 on an edge, 9 inside). A result trails its pixel
// by one row plus one pixel; after the last pixel the user sends
// image_width + 1 drain transactions (tuser = 1) to flush the rest, and the
// final result of the frame carries tlast. A drain sent before the frame's
// pixels are all in is accepted and dropped; a pixel sent while draining
// counts as a drain. Writing either register restarts the frame. Both line
// stores share one single-port-read memory, read on accept and written back
// in the next cycle, so the block holds one transaction at a time: a dropped
// drain is only accepted, one without a result ends after the window update,
// and one with a result goes on through sum, reciprocal multiply and output
// load, plus any wait for the output register. The output register lets the
// next transaction enter while a result waits. No clearing pass after reset.
`default_nettype none

module box_blur_3x3_edge_clipped #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bb3_pkg::PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
    input  wire logic                           s_axis_tuser,  // req_type
    // master stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [bb3_pkg::PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
    output logic                                m_axis_tlast,  // frame_last
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [bb3_pkg::CFG_D_BITS-1:0] i_cfg_data
);

    import bb3_pkg::*;

    localparam int unsigned AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned W_CLAMP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

    // config registers and their effective values
    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic [CFG_W_BITS-1:0] w_eff;
    logic [CFG_H_BITS-1:0] h_eff;

    // frame position
    logic [CFG_W_BITS-1:0] r_col;
    logic [ROW_BITS-1:0]   r_row;

    // transaction held while it is worked on
    logic [PIX_W-1:0]      r_pix;
    logic                  r_emit;
    logic                  r_last;
    logic [2:0]            r_row_use;
    logic [2:0]            r_col_use;
    logic [AW-1:0]         r_addr;

    // output register
    logic                  r_ovalid;
    logic [PIX_W-1:0]      r_odata;
    logic                  r_olast;

    t_state                r_state, n_state;

    // decode of the incoming transaction
    logic                  accept;
    logic                  drain_req;
    logic                  in_drain;
    logic                  proceed;
    logic [CFG_W_BITS-1:0] col_c;
    logic [CFG_W_BITS:0]   col_nxt;
    logic                  wrap;
    logic                  emit;
    logic                  col_zero;
    logic [ROW_BITS-1:0]   row_ctr;
    logic [CFG_H_BITS-1:0] r_ctr;
    logic [CFG_W_BITS-1:0] c_ctr;
    logic [2:0]            row_use;
    logic [2:0]            col_use;
    logic                  last;
    logic [PIX_W-1:0]      pix;

    // sequencer outputs
    logic                  mem_rd;
    logic                  mem_wr;
    logic                  div_en;
    logic                  out_load;
    t_win_ctrl             win_ctrl;

    logic [2*PIX_W-1:0]    mem_rdata;
    t_win_sum              win_sum;
    logic [CH_W-1:0]       q_red, q_green, q_blue;

    // width 0 acts as 1, oversize clamps to the line store depth
    always_comb begin
        if (r_width == '0) begin
            w_eff = CFG_W_BITS'(1);
        end else if (r_width > CFG_W_BITS'(W_CLAMP)) begin
            w_eff = CFG_W_BITS'(W_CLAMP);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? CFG_H_BITS'(1) : r_height;
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign drain_req = (s_axis_tuser == REQ_DRAIN);
    assign in_drain  = (r_row >= {1'b0, h_eff});
    // early drains are swallowed without touching state
    assign proceed   = !(drain_req && !in_drain);

    always_comb begin
        col_c    = (r_col >= w_eff) ? '0 : r_col;
        col_nxt  = {1'b0, col_c} + (CFG_W_BITS + 1)'(1);
        wrap     = (col_nxt >= {1'b0, w_eff});
        emit     = (r_row >= ROW_BITS'(2)) || ((r_row == ROW_BITS'(1)) && (col_c != '0));
        col_zero = (col_c == '0);
        // at column 0 the finished pixel is the right end of two rows up
        row_ctr  = col_zero ? (r_row - ROW_BITS'(2)) : (r_row - ROW_BITS'(1));
        r_ctr    = row_ctr[CFG_H_BITS-1:0];
        c_ctr    = col_zero ? (w_eff - CFG_W_BITS'(1)) : (col_c - CFG_W_BITS'(1));
        row_use  = {(({1'b0, r_ctr} + ROW_BITS'(1)) < {1'b0, h_eff}), 1'b1, (r_ctr != '0)};
        col_use  = {(({1'b0, c_ctr} + (CFG_W_BITS + 1)'(1)) < {1'b0, w_eff}), 1'b1,
                    (c_ctr != '0)};
        last     = (({1'b0, r_ctr} + ROW_BITS'(1)) == {1'b0, h_eff})
                && (({1'b0, c_ctr} + (CFG_W_BITS + 1)'(1)) == {1'b0, w_eff});
        // window keeps red in the high byte; drains feed zeros
        pix      = in_drain ? '0 : {s_axis_tdata[0 +: CH_W], s_axis_tdata[CH_W +: CH_W],
                                    s_axis_tdata[2*CH_W +: CH_W]};
    end

    // config registers and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (accept && proceed) begin
                if (emit && last) begin
                    // final result of the frame, start over
                    r_col <= '0;
                    r_row <= '0;
                end else if (wrap) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_BITS'(1);
                end else begin
                    r_col <= col_nxt[CFG_W_BITS-1:0];
                end
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  r_width  <= i_cfg_data[CFG_W_BITS-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[CFG_H_BITS-1:0];
                endcase
                r_col <= '0;
                r_row <= '0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (accept && proceed) begin
            r_pix     <= pix;
            r_emit    <= emit;
            r_last    <= last;
            r_row_use <= row_use;
            r_col_use <= col_use;
            r_addr    <= AW'(col_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: read, window update and write-back, sum, multiply, output
    always_comb begin
        n_state          = r_state;
        s_axis_tready    = 1'b0;
        mem_rd           = 1'b0;
        mem_wr           = 1'b0;
        div_en           = 1'b0;
        out_load         = 1'b0;
        win_ctrl.shift   = 1'b0;
        win_ctrl.sum_en  = 1'b0;
        win_ctrl.row_use = r_row_use;
        win_ctrl.col_use = r_col_use;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && proceed) begin
                    mem_rd  = 1'b1;
                    n_state = ST_WIN;
                end
            end
            ST_WIN: begin
                win_ctrl.shift = 1'b1;
                mem_wr         = 1'b1;
                n_state        = r_emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                win_ctrl.sum_en = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                div_en  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // line stores: upper in the high half, middle in the low half
    bb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (2 * PIX_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd),
        .i_rd_addr (AW'(col_c)),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_addr),
        .i_wr_data ({mem_rdata[0 +: PIX_W], r_pix}),
        .o_rd_data (mem_rdata)
    );

    bb3_win u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (win_ctrl),
        .i_upper  (mem_rdata[PIX_W +: PIX_W]),
        .i_middle (mem_rdata[0 +: PIX_W]),
        .i_pix    (r_pix),
        .o_sum    (win_sum)
    );

    bb3_div u_div (
        .i_clk   (i_clk),
        .i_en    (div_en),
        .i_sum   (win_sum),
        .o_red   (q_red),
        .o_green (q_green),
        .o_blue  (q_blue)
    );

    // output register, frees the pipeline while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= {q_blue, q_green, q_red};
            r_olast <= r_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // column never leaves the active width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < w_eff)
        else $error("column counter outside active width");

    // rows run at most to one above the frame height during the drain
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ({1'b0, h_eff} + ROW_BITS'(1)))
        else $error("row counter beyond drain range");

    // the final result of a frame has already restarted the counters
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIN && r_emit && r_last) |-> (r_col == '0 && r_row == '0))
        else $error("frame counters not restarted after last result");

    // a result leaving the multiplier lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) |=>
            (r_ovalid && r_state == ST_IDLE))
        else $error("result lost on output load");

endmodule

`default_nettype wire
